FILE: rtl/core/fnv1a_pkg.sv
// shared types and constants for the fnv-1a string hash block
// no dependencies; used by every module of the block by scoped name
`default_nettype none

package fnv1a_pkg;

    localparam int HASH_W  = 64;
    localparam int SIZE_W  = 25;
    localparam int INDEX_W = 24;
    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int CNT_W   = 6;

    localparam logic [HASH_W-1:0] OFFSET_BASIS = 64'd2166136261;
    localparam logic [SIZE_W-1:0] TABLE_RESET  = 25'd1024;
    localparam logic [SIZE_W-1:0] TABLE_MAX    = 25'd16777216;
    localparam logic [CNT_W-1:0]  DIV_LAST_CNT = 6'd63;

    // register index, taken from paddr[2]
    localparam logic REG_TABLE_SIZE = 1'b0;

    // commands from the controller to the datapath
    typedef struct packed {
        logic acc_xor;
        logic acc_mul;
        logic div_load;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/fnv1a_cfg.sv
// apb register file holding the table size
// depends on fnv1a_pkg
`default_nettype none

module fnv1a_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fnv1a_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fnv1a_pkg::DATA_W-1:0]   pwdata,
    output logic      [fnv1a_pkg::DATA_W-1:0]   prdata,
    output logic      [fnv1a_pkg::SIZE_W-1:0]   eff_size
);

    logic [fnv1a_pkg::SIZE_W-1:0] size_reg;
    logic [fnv1a_pkg::SIZE_W-1:0] size_next;
    logic                         wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == fnv1a_pkg::REG_TABLE_SIZE);

    always_comb
    begin
        size_next = size_reg;
        if (wr_en)
        begin
            size_next = pwdata[fnv1a_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= fnv1a_pkg::TABLE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == fnv1a_pkg::REG_TABLE_SIZE)
        begin
            prdata = {{(fnv1a_pkg::DATA_W-fnv1a_pkg::SIZE_W){1'b0}}, size_reg};
        end
    end

    // zero acts as one, anything above 2^24 saturates
    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = {{(fnv1a_pkg::SIZE_W-1){1'b0}}, 1'b1};
        end
        else if (size_reg > fnv1a_pkg::TABLE_MAX)
        begin
            eff_size = fnv1a_pkg::TABLE_MAX;
        end
        else
        begin
            eff_size = size_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fnv1a_ctrl.sv
// controller: sequences xor, multiply, bit-serial modulo and result hand-off
// depends on fnv1a_pkg
`default_nettype none

module fnv1a_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               byte_valid,
    input  wire logic               last,
    input  wire logic               out_ready,
    output logic                    in_ready,
    output logic                    out_valid,
    output fnv1a_pkg::dp_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic                        last_reg;
    logic                        last_next;
    logic [fnv1a_pkg::CNT_W-1:0] cnt_reg;
    logic [fnv1a_pkg::CNT_W-1:0] cnt_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        accept;
    logic                        out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = last;
                    if (byte_valid)
                    begin
                        cmd.acc_xor = 1'b1;
                        state_next  = ST_MUL;
                    end
                    else if (last)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.acc_mul = 1'b1;
                state_next  = last_reg ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == fnv1a_pkg::DIV_LAST_CNT)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait here while an earlier result is still unclaimed
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fnv1a_dp.sv
// datapath: hash accumulator, constant multiply, restoring divider, result registers
// depends on fnv1a_pkg
`default_nettype none

module fnv1a_dp
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fnv1a_pkg::dp_cmd_t              cmd,
    input  wire logic [fnv1a_pkg::BYTE_W-1:0]    byte_value,
    input  wire logic [fnv1a_pkg::SIZE_W-1:0]    eff_size,
    output logic      [fnv1a_pkg::HASH_W-1:0]    hash_value,
    output logic      [fnv1a_pkg::INDEX_W-1:0]   bucket_index
);

    logic [fnv1a_pkg::HASH_W-1:0]  acc_reg;
    logic [fnv1a_pkg::HASH_W-1:0]  acc_next;
    logic [fnv1a_pkg::HASH_W-1:0]  acc_prod;
    logic [fnv1a_pkg::HASH_W-1:0]  byte_sext;
    logic [fnv1a_pkg::HASH_W-1:0]  dvd_reg;
    logic [fnv1a_pkg::HASH_W-1:0]  hold_reg;
    logic [fnv1a_pkg::SIZE_W-1:0]  rem_reg;
    logic [fnv1a_pkg::SIZE_W:0]    rem_shift;
    logic [fnv1a_pkg::SIZE_W:0]    rem_sub;
    logic [fnv1a_pkg::SIZE_W-1:0]  rem_next;
    logic [fnv1a_pkg::HASH_W-1:0]  hash_out_reg;
    logic [fnv1a_pkg::INDEX_W-1:0] bucket_out_reg;

    assign byte_sext = {{(fnv1a_pkg::HASH_W-fnv1a_pkg::BYTE_W){byte_value[fnv1a_pkg::BYTE_W-1]}},
                        byte_value};

    // prime 16777619 = 2^24 + 256 + 128 + 16 + 2 + 1
    assign acc_prod = (acc_reg << 24) + (acc_reg << 8) + (acc_reg << 7)
                    + (acc_reg << 4) + (acc_reg << 1) + acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_xor)
        begin
            acc_next = acc_reg ^ byte_sext;
        end
        else if (cmd.acc_mul)
        begin
            acc_next = acc_prod;
        end
        else if (cmd.div_load)
        begin
            acc_next = fnv1a_pkg::OFFSET_BASIS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= fnv1a_pkg::OFFSET_BASIS;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // one quotient bit per cycle, msb of the dividend first
    assign rem_shift = {rem_reg, dvd_reg[fnv1a_pkg::HASH_W-1]};
    assign rem_sub   = rem_shift - {1'b0, eff_size};
    assign rem_next  = (rem_shift >= {1'b0, eff_size}) ? rem_sub[fnv1a_pkg::SIZE_W-1:0]
                                                       : rem_shift[fnv1a_pkg::SIZE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvd_reg  <= acc_reg;
            hold_reg <= acc_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            hash_out_reg   <= hold_reg;
            bucket_out_reg <= rem_reg[fnv1a_pkg::INDEX_W-1:0];
        end
    end

    assign hash_value   = hash_out_reg;
    assign bucket_index = bucket_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fnv1a_string_bucket_index_top.sv
// fnv-1a string hash with bucket index
// input channel: one string byte per item (byte_value, byte_valid, last), valid/ready
// output channel: hash_value and bucket_index, one item per string, valid/ready
// config: apb-style port, table_size at address 0, pready always high
// a byte item is xored into the accumulator as it is accepted, then multiplied
// by the prime in the mul state; an item with last then loads the divider,
// takes the remainder of the hash by table_size one bit per cycle, and moves the
// result out once the output register is free
// the result sits in an output register; while it waits for out_ready the
// next string's bytes are still taken, and only the next result waits
// reset sets the accumulator to the offset basis, table_size to 1024 and
// clears out_valid
// table_size zero acts as one; values above 2^24 act as 2^24
// depends on fnv1a_pkg, fnv1a_cfg, fnv1a_ctrl, fnv1a_dp
`default_nettype none

module fnv1a_string_bucket_index_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fnv1a_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [fnv1a_pkg::DATA_W-1:0]    pwdata,
    output logic      [fnv1a_pkg::DATA_W-1:0]    prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [fnv1a_pkg::BYTE_W-1:0]    byte_value,
    input  wire logic                            byte_valid,
    input  wire logic                            last,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [fnv1a_pkg::HASH_W-1:0]    hash_value,
    output logic      [fnv1a_pkg::INDEX_W-1:0]   bucket_index
);

    fnv1a_pkg::dp_cmd_t           cmd;
    logic [fnv1a_pkg::SIZE_W-1:0] eff_size;

    assign pready = 1'b1;

    fnv1a_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .eff_size (eff_size)
    );

    fnv1a_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .byte_valid (byte_valid),
        .last       (last),
        .out_ready  (out_ready),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    fnv1a_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .byte_value   (byte_value),
        .eff_size     (eff_size),
        .hash_value   (hash_value),
        .bucket_index (bucket_index)
    );

endmodule

`default_nettype wire
